// ===== hw/rtl/wpp_pkg.sv =====
// ============================================================================
// wpp_pkg
// Shared types and constants of the WAV PCM stream parser.
// ============================================================================
package wpp_pkg;

    localparam int HEADER_BYTES     = 44;
    localparam int MAX_SAMPLE_BYTES = 4;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } result_kind_t;

    localparam logic [2:0] ERR_NOT_RIFF_WAVE = 3'd0;
    localparam logic [2:0] ERR_BAD_FMT_TAG   = 3'd1;
    localparam logic [2:0] ERR_NOT_PCM       = 3'd2;
    localparam logic [2:0] ERR_NO_DATA_TAG   = 3'd3;
    localparam logic [2:0] ERR_EMPTY_DATA    = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [2:0]   error_code;
        logic         channel;
        logic [31:0]  sample_bits;
        logic         last_sample;
        logic [31:0]  riff_size;
        logic [15:0]  channel_count;
        logic [31:0]  rate_hz;
        logic [31:0]  bytes_per_second;
        logic [15:0]  frame_bytes;
        logic [15:0]  bits_per_sample;
        logic [31:0]  data_bytes;
    } result_t;

endpackage

// ===== hw/rtl/wpp_in_stage.sv =====
// ============================================================================
// wpp_in_stage
// Input register of the parser: holds one item until the parser takes it.
// ============================================================================
module wpp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  wpp_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output wpp_pkg::in_item_t item
);
    import wpp_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign s_axis_tready = !valid_reg || advance;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== hw/rtl/wpp_parser.sv =====
// ============================================================================
// wpp_parser
// Parser state and the single-pass logic that handles one byte per cycle while fire is high.
// ============================================================================
module wpp_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       data_byte,
    input  logic             start,
    output logic             res_valid,
    output wpp_pkg::result_t res
);
    import wpp_pkg::*;

    localparam logic [5:0] HEADER_LAST = 6'(HEADER_BYTES - 1);
    localparam logic [2:0] NB_MAX      = 3'(MAX_SAMPLE_BYTES);

    function automatic logic [7:0] tag_byte(input logic [5:0] p);
        logic [7:0] t;
        unique case (p)
            6'd0:    t = 8'h52;
            6'd1:    t = 8'h49;
            6'd2:    t = 8'h46;
            6'd3:    t = 8'h46;
            6'd8:    t = 8'h57;
            6'd9:    t = 8'h41;
            6'd10:   t = 8'h56;
            6'd11:   t = 8'h45;
            6'd12:   t = 8'h66;
            6'd13:   t = 8'h6D;
            6'd14:   t = 8'h74;
            6'd15:   t = 8'h20;
            6'd36:   t = 8'h64;
            6'd37:   t = 8'h61;
            6'd38:   t = 8'h74;
            6'd39:   t = 8'h61;
            default: t = 8'h00;
        endcase
        return t;
    endfunction

    function automatic logic [31:0] put32(input logic [31:0] f, input logic [7:0] b,
                                          input logic [1:0] k);
        logic [31:0] r;
        r = f;
        r[8*k +: 8] = r[8*k +: 8] | b;
        return r;
    endfunction

    function automatic logic [15:0] put16(input logic [15:0] f, input logic [7:0] b,
                                          input logic k);
        logic [15:0] r;
        r = f;
        r[8*k +: 8] = r[8*k +: 8] | b;
        return r;
    endfunction

    phase_t      phase_reg, phase_next, phase_cur;
    logic [5:0]  pos_reg, pos_next, pos_cur;
    logic        tag_ok_reg, tag_ok_next, tag_ok_cur;
    logic [31:0] size_reg, size_next, size_cur;
    logic [15:0] fmt_reg, fmt_next, fmt_cur;
    logic [15:0] chan_reg, chan_next, chan_cur;
    logic [31:0] rate_reg, rate_next, rate_cur;
    logic [31:0] brate_reg, brate_next, brate_cur;
    logic [15:0] align_reg, align_next, align_cur;
    logic [15:0] depth_reg, depth_next, depth_cur;
    logic [31:0] length_reg, length_next, length_cur;
    logic [31:0] left_reg, left_next, left_cur;
    logic [31:0] accum_reg, accum_next, accum_cur;
    logic [1:0]  bis_reg, bis_next, bis_cur;
    logic        toggle_reg, toggle_next, toggle_cur;

    logic        restart;
    logic        tag_bit;
    logic [15:0] fmt_new;
    logic [31:0] length_new;
    logic [12:0] depth_bytes;
    logic [2:0]  nb;
    logic        last;

    assign restart = fire && start;

    always_comb
    begin
        phase_cur  = restart ? PH_HEADER : phase_reg;
        pos_cur    = restart ? 6'd0 : pos_reg;
        tag_ok_cur = restart ? 1'b1 : tag_ok_reg;
        size_cur   = restart ? 32'd0 : size_reg;
        fmt_cur    = restart ? 16'd0 : fmt_reg;
        chan_cur   = restart ? 16'd0 : chan_reg;
        rate_cur   = restart ? 32'd0 : rate_reg;
        brate_cur  = restart ? 32'd0 : brate_reg;
        align_cur  = restart ? 16'd0 : align_reg;
        depth_cur  = restart ? 16'd0 : depth_reg;
        length_cur = restart ? 32'd0 : length_reg;
        left_cur   = restart ? 32'd0 : left_reg;
        accum_cur  = restart ? 32'd0 : accum_reg;
        bis_cur    = restart ? 2'd0 : bis_reg;
        toggle_cur = restart ? 1'b0 : toggle_reg;

        phase_next  = phase_cur;
        pos_next    = pos_cur;
        tag_ok_next = tag_ok_cur;
        size_next   = size_cur;
        fmt_next    = fmt_cur;
        chan_next   = chan_cur;
        rate_next   = rate_cur;
        brate_next  = brate_cur;
        align_next  = align_cur;
        depth_next  = depth_cur;
        length_next = length_cur;
        left_next   = left_cur;
        accum_next  = accum_cur;
        bis_next    = bis_cur;
        toggle_next = toggle_cur;

        res_valid  = 1'b0;
        res        = '0;
        tag_bit    = tag_ok_cur && (data_byte == tag_byte(pos_cur));
        fmt_new    = put16(fmt_cur, data_byte, pos_cur[0]);
        length_new = put32(length_cur, data_byte, pos_cur[1:0]);

        depth_bytes = depth_cur[15:3];
        if (depth_bytes == 13'd0)
        begin
            nb = 3'd1;
        end
        else if (depth_bytes > 13'(MAX_SAMPLE_BYTES))
        begin
            nb = NB_MAX;
        end
        else
        begin
            nb = depth_bytes[2:0];
        end
        last = (left_cur == 32'd1);

        if (fire)
        begin
            unique case (phase_cur)
                PH_HEADER:
                begin
                    pos_next = pos_cur + 6'd1;
                    if (pos_cur < 6'd4)
                    begin
                        tag_ok_next = tag_bit;
                    end
                    else if (pos_cur < 6'd8)
                    begin
                        size_next = put32(size_cur, data_byte, pos_cur[1:0]);
                    end
                    else if (pos_cur < 6'd16)
                    begin
                        tag_ok_next = tag_bit;
                        if ((pos_cur == 6'd11) || (pos_cur == 6'd15))
                        begin
                            if (!tag_bit)
                            begin
                                res_valid      = 1'b1;
                                res.result_kind = KIND_ERROR;
                                res.error_code = (pos_cur == 6'd11) ? ERR_NOT_RIFF_WAVE
                                                                    : ERR_BAD_FMT_TAG;
                                phase_next     = PH_DONE;
                            end
                            else
                            begin
                                tag_ok_next = 1'b1;
                            end
                        end
                    end
                    else if (pos_cur < 6'd20)
                    begin
                        tag_ok_next = tag_ok_cur;
                    end
                    else if (pos_cur < 6'd22)
                    begin
                        fmt_next = fmt_new;
                        if ((pos_cur == 6'd21) && (fmt_new != 16'd1))
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_NOT_PCM;
                            phase_next      = PH_DONE;
                        end
                    end
                    else if (pos_cur < 6'd24)
                    begin
                        chan_next = put16(chan_cur, data_byte, pos_cur[0]);
                    end
                    else if (pos_cur < 6'd28)
                    begin
                        rate_next = put32(rate_cur, data_byte, pos_cur[1:0]);
                    end
                    else if (pos_cur < 6'd32)
                    begin
                        brate_next = put32(brate_cur, data_byte, pos_cur[1:0]);
                    end
                    else if (pos_cur < 6'd34)
                    begin
                        align_next = put16(align_cur, data_byte, pos_cur[0]);
                    end
                    else if (pos_cur < 6'd36)
                    begin
                        depth_next = put16(depth_cur, data_byte, pos_cur[0]);
                    end
                    else if (pos_cur < 6'd40)
                    begin
                        tag_ok_next = tag_bit;
                        if (pos_cur == 6'd39)
                        begin
                            if (!tag_bit)
                            begin
                                res_valid       = 1'b1;
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_NO_DATA_TAG;
                                phase_next      = PH_DONE;
                            end
                            else
                            begin
                                tag_ok_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        length_next = length_new;
                        if (pos_cur >= HEADER_LAST)
                        begin
                            res_valid = 1'b1;
                            if (length_new == 32'd0)
                            begin
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_EMPTY_DATA;
                                phase_next      = PH_DONE;
                            end
                            else
                            begin
                                phase_next           = PH_DATA;
                                left_next            = length_new;
                                accum_next           = 32'd0;
                                bis_next             = 2'd0;
                                toggle_next          = 1'b0;
                                res.result_kind      = KIND_HEADER;
                                res.riff_size        = size_cur;
                                res.channel_count    = chan_cur;
                                res.rate_hz          = rate_cur;
                                res.bytes_per_second = brate_cur;
                                res.frame_bytes      = align_cur;
                                res.bits_per_sample  = depth_cur;
                                res.data_bytes       = length_new;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    accum_next = put32(accum_cur, data_byte, bis_cur);
                    bis_next   = bis_cur + 2'd1;
                    left_next  = left_cur - 32'd1;
                    if (last || (bis_next == nb[1:0]))
                    begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_SAMPLE;
                        res.sample_bits = accum_next;
                        res.last_sample = last;
                        if (chan_cur == 16'd1)
                        begin
                            res.channel = 1'b0;
                        end
                        else
                        begin
                            res.channel = toggle_cur;
                            toggle_next = !toggle_cur;
                        end
                        accum_next = 32'd0;
                        bis_next   = 2'd0;
                        if (last)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_cur;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= 6'd0;
            tag_ok_reg <= 1'b1;
            size_reg   <= 32'd0;
            fmt_reg    <= 16'd0;
            chan_reg   <= 16'd0;
            rate_reg   <= 32'd0;
            brate_reg  <= 32'd0;
            align_reg  <= 16'd0;
            depth_reg  <= 16'd0;
            length_reg <= 32'd0;
            left_reg   <= 32'd0;
            accum_reg  <= 32'd0;
            bis_reg    <= 2'd0;
            toggle_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tag_ok_reg <= tag_ok_next;
            size_reg   <= size_next;
            fmt_reg    <= fmt_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            brate_reg  <= brate_next;
            align_reg  <= align_next;
            depth_reg  <= depth_next;
            length_reg <= length_next;
            left_reg   <= left_next;
            accum_reg  <= accum_next;
            bis_reg    <= bis_next;
            toggle_reg <= toggle_next;
        end
    end

    // The header walk always leaves the header phase by its last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (pos_reg <= HEADER_LAST))
        else $error("header position ran past the header");

    // In the data phase there is always at least one byte still expected.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (left_reg != 32'd0))
        else $error("data phase with no bytes left");

    // Samples come only from bytes of the data chunk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && (res.result_kind == KIND_SAMPLE))
            |-> ((phase_reg == PH_DATA) && !start))
        else $error("sample produced outside the data chunk");

endmodule

// ===== hw/rtl/wpp_out_stage.sv =====
// ============================================================================
// wpp_out_stage
// Result register: holds one result until the downstream side takes it.
// ============================================================================
module wpp_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             res_valid,
    input  wpp_pkg::result_t res,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output wpp_pkg::result_t m_res
);
    import wpp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign m_axis_tvalid = valid_reg;
    assign m_res         = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== hw/rtl/wav_pcm_stream_parser_core.sv =====
// ============================================================================
// wav_pcm_stream_parser_core
// Parses a canonical 44-byte RIFF WAVE PCM header and unpacks the data chunk.
// ============================================================================
// The block takes one file byte per cycle as long as the result side keeps
// up. Each item passes an input register, one pass of parse logic and a
// result register, and the result register captures its result as the
// parse logic takes its byte. A result held by a stalled receiver also holds
// back the input, including bytes that cause no result. An item with tuser
// high starts a new file. The header gives one header result or one error
// result; data bytes give one sample result per completed sample, with tlast
// on the final one.
module wav_pcm_stream_parser_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic         s_axis_tuser,  // [0] start_of_file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] error_code, [3] channel, [35:4] sample_bits, [67:36] riff_size,
    // [83:68] channel_count, [115:84] rate_hz, [147:116] bytes_per_second,
    // [163:148] frame_bytes, [179:164] bits_per_sample, [211:180] data_bytes,
    // [215:212] zero
    output logic [215:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // [1:0] result_kind
    output logic         m_axis_tlast   // last_sample
);
    import wpp_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_valid;
    logic     advance;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_item.data_byte     = s_axis_tdata;
    assign s_item.start_of_file = s_axis_tuser;

    assign m_axis_tvalid = out_valid;
    assign advance       = item_valid && (!out_valid || m_axis_tready);

    wpp_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_item        (s_item),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    wpp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .data_byte (item.data_byte),
        .start     (item.start_of_file),
        .res_valid (res_valid),
        .res       (res)
    );

    wpp_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .res_valid     (res_valid),
        .res           (res),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (m_axis_tready),
        .m_res         (m_res)
    );

    assign m_axis_tuser = m_res.result_kind;
    assign m_axis_tlast = m_res.last_sample;
    assign m_axis_tdata = {4'd0,
                           m_res.data_bytes,
                           m_res.bits_per_sample,
                           m_res.frame_bytes,
                           m_res.bytes_per_second,
                           m_res.rate_hz,
                           m_res.channel_count,
                           m_res.riff_size,
                           m_res.sample_bits,
                           m_res.channel,
                           m_res.error_code};

endmodule
